/* sv/mpq_pkg.sv */
// Shared types and codes for the multilevel priority ready queue.
// Depends on nothing; imported by the queue top level and its checker.
package mpq_pkg;

  // Request kinds carried in the input transfer.
  localparam logic [1:0] KIND_ENQ    = 2'd0;
  localparam logic [1:0] KIND_DEQ    = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_PRIO = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_EMPTY    = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] thread_id;
    logic [2:0]  priority_req;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_thread_id;
    logic [1:0]  out_level;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR
  } state_t;

endpackage

/* sv/multilevel_priority_ready_queue.sv */
// Multilevel priority ready queue: one FIFO of thread ids per priority level.
// Enqueue, its errors and the unused kind strobe a result in the cycle after start.
// Dequeue and remove stay busy while they scan the levels from level 0, reading and
// comparing entries, then move each later entry toward the head and shrink the level.
// Busy drops as the result strobes, so the next transfer may be accepted then.
// Reset (synchronous, rst_n low) empties all levels at once.
module multilevel_priority_ready_queue
  import mpq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int NUM_LEVELS  = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_strobe,
  output out_item_t out_item
);

  localparam int LW = $clog2(NUM_LEVELS);
  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // Entry memory, one row per level, head at slot zero.
  logic [15:0] mem [NUM_LEVELS][QUEUE_DEPTH];
  logic [15:0] rdata_r;

  logic [CW-1:0] cnt_r [NUM_LEVELS];

  state_t        state_r, state_nxt;
  logic [LW-1:0] lvl_r, lvl_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic          is_deq_r, is_deq_nxt;
  logic [15:0]   tid_r, tid_nxt;
  logic          out_strobe_r, out_strobe_nxt;
  out_item_t     out_item_r, out_item_nxt;

  logic          mem_we;
  logic [LW-1:0] mem_wl;
  logic [PW-1:0] mem_wp;
  logic [15:0]   mem_wd;
  logic [PW-1:0] rd_pos;
  logic [CW-1:0] pos_inc;
  logic [LW-1:0] enq_lvl;
  logic          cnt_inc, cnt_dec;
  logic [LW-1:0] cnt_lvl;

  assign pos_inc = pos_r + CW'(1);
  assign enq_lvl = LW'(in_item.priority_req);
  assign rd_pos  = (state_r == S_SHIFT_RD) ? pos_inc[PW-1:0] : pos_r[PW-1:0];

  // Memory write port and registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wl][mem_wp] <= mem_wd;
    end
    rdata_r <= mem[lvl_r][rd_pos];
  end

  // Per-level fill counts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (cnt_inc) begin
      cnt_r[cnt_lvl] <= cnt_r[cnt_lvl] + CW'(1);
    end else if (cnt_dec) begin
      cnt_r[cnt_lvl] <= cnt_r[cnt_lvl] - CW'(1);
    end
  end

  // Sequencer and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
    lvl_r      <= lvl_nxt;
    pos_r      <= pos_nxt;
    is_deq_r   <= is_deq_nxt;
    tid_r      <= tid_nxt;
    out_item_r <= out_item_nxt;
  end

  // Next state: enqueue finishes at once; dequeue and remove share the
  // scan loop (dequeue matches any entry) and the gap-closing loop.
  always_comb begin
    state_nxt      = state_r;
    lvl_nxt        = lvl_r;
    pos_nxt        = pos_r;
    is_deq_nxt     = is_deq_r;
    tid_nxt        = tid_r;
    out_strobe_nxt = 1'b0;
    out_item_nxt   = out_item_r;
    mem_we         = 1'b0;
    mem_wl         = lvl_r;
    mem_wp         = pos_r[PW-1:0];
    mem_wd         = rdata_r;
    cnt_inc        = 1'b0;
    cnt_dec        = 1'b0;
    cnt_lvl        = lvl_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          out_item_nxt = '{status: ST_EMPTY, out_thread_id: '0, out_level: '0};
          case (in_item.kind)
            KIND_ENQ: begin
              out_strobe_nxt = 1'b1;
              if (int'(in_item.priority_req) >= NUM_LEVELS) begin
                out_item_nxt.status = ST_BAD_PRIO;
              end else if (cnt_r[enq_lvl] == CW'(QUEUE_DEPTH)) begin
                out_item_nxt.status = ST_FULL;
              end else begin
                out_item_nxt.status = ST_OK;
                mem_we  = 1'b1;
                mem_wl  = enq_lvl;
                mem_wp  = cnt_r[enq_lvl][PW-1:0];
                mem_wd  = in_item.thread_id;
                cnt_inc = 1'b1;
                cnt_lvl = enq_lvl;
              end
            end
            KIND_DEQ, KIND_REMOVE: begin
              is_deq_nxt = (in_item.kind == KIND_DEQ);
              tid_nxt    = in_item.thread_id;
              lvl_nxt    = '0;
              pos_nxt    = '0;
              state_nxt  = S_SCAN_RD;
            end
            default: begin
              out_strobe_nxt = 1'b1;
            end
          endcase
        end
      end

      S_SCAN_RD: begin
        if (pos_r == cnt_r[lvl_r]) begin
          // End of this level: move on, or report nothing found.
          if (lvl_r == LW'(NUM_LEVELS - 1)) begin
            out_strobe_nxt = 1'b1;
            out_item_nxt   = '{status: ST_EMPTY, out_thread_id: '0, out_level: '0};
            state_nxt      = S_IDLE;
          end else begin
            lvl_nxt = lvl_r + LW'(1);
            pos_nxt = '0;
          end
        end else begin
          state_nxt = S_SCAN_CMP;
        end
      end

      S_SCAN_CMP: begin
        if (is_deq_r || rdata_r == tid_r) begin
          tid_nxt   = rdata_r;
          state_nxt = S_SHIFT_RD;
        end else begin
          pos_nxt   = pos_inc;
          state_nxt = S_SCAN_RD;
        end
      end

      S_SHIFT_RD: begin
        if (pos_inc < cnt_r[lvl_r]) begin
          state_nxt = S_SHIFT_WR;
        end else begin
          cnt_dec        = 1'b1;
          out_strobe_nxt = 1'b1;
          out_item_nxt   = '{status: ST_OK, out_thread_id: tid_r, out_level: 2'(lvl_r)};
          state_nxt      = S_IDLE;
        end
      end

      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        pos_nxt   = pos_inc;
        state_nxt = S_SHIFT_RD;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy       = (state_r != S_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

/* sv/mpq_checker.sv */
// Port-level checker for the multilevel priority ready queue, with its bind.
// Depends on mpq_pkg and on the multilevel_priority_ready_queue ports.
module mpq_checker
  import mpq_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_strobe,
  input out_item_t out_item
);

  // An accepted transfer either gives its result next cycle or keeps busy.
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (out_strobe || busy))
    else $error("accepted request neither answered nor busy");

  // Busy falls only together with a result.
  a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_strobe)
    else $error("busy dropped without a result");

  // Failed requests carry zero id and level.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status != ST_OK) |->
      (out_item.out_thread_id == 16'd0 && out_item.out_level == 2'd0))
    else $error("failed result carries nonzero fields");

  // Enqueue errors are reported in the cycle right after acceptance.
  a_enq_err_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_item.status == ST_BAD_PRIO || out_item.status == ST_FULL)) |->
      $past(start && !busy && in_item.kind == KIND_ENQ))
    else $error("enqueue error not reported at once");

endmodule

bind multilevel_priority_ready_queue mpq_checker u_mpq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_item    (in_item),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

/* verif/tb.sv */
// Self-checking testbench for the multilevel priority ready queue.
// Depends on mpq_pkg and multilevel_priority_ready_queue; it needs no other file.
`timescale 1ns / 100ps

module tb;
  import mpq_pkg::*;

  localparam int QDEPTH = 16;
  localparam int NLEVELS = 4;
  // The fourth request kind has no function and must report empty.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_strobe;
  out_item_t out_item;

  // Scoreboard copy of the four ready queues.
  logic [15:0] ready_ids [NLEVELS][QDEPTH];
  int          ready_fill [NLEVELS] = '{default: 0};

  out_item_t pending_results[$];
  out_item_t oldest_result;
  int        fail_count = 0;

  multilevel_priority_ready_queue #(
    .QUEUE_DEPTH(QDEPTH),
    .NUM_LEVELS (NLEVELS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Delete one entry of a level and close the gap toward the head.
  function automatic void drop_ready_entry(input int lvl, input int pos);
    for (int i = pos; i + 1 < ready_fill[lvl]; i++) begin
      ready_ids[lvl][i] = ready_ids[lvl][i + 1];
    end
    ready_fill[lvl]--;
  endfunction

  // Apply one accepted request to the scoreboard queues and return its result.
  function automatic out_item_t schedule_outcome(input in_item_t req);
    out_item_t res;
    bit        found;
    res = '0;
    res.status = ST_EMPTY;
    found = 1'b0;
    case (req.kind)
      KIND_ENQ: begin
        if (req.priority_req >= NLEVELS) begin
          res.status = ST_BAD_PRIO;
        end else if (ready_fill[req.priority_req] >= QDEPTH) begin
          res.status = ST_FULL;
        end else begin
          ready_ids[req.priority_req][ready_fill[req.priority_req]] = req.thread_id;
          ready_fill[req.priority_req]++;
          res.status = ST_OK;
        end
      end
      KIND_DEQ: begin
        for (int lvl = 0; lvl < NLEVELS && !found; lvl++) begin
          if (ready_fill[lvl] != 0) begin
            res.out_thread_id = ready_ids[lvl][0];
            res.out_level = 2'(lvl);
            res.status = ST_OK;
            drop_ready_entry(lvl, 0);
            found = 1'b1;
          end
        end
      end
      KIND_REMOVE: begin
        // Search from level 0 down, head to tail; only the first match goes.
        for (int lvl = 0; lvl < NLEVELS && !found; lvl++) begin
          for (int pos = 0; pos < ready_fill[lvl] && !found; pos++) begin
            if (ready_ids[lvl][pos] == req.thread_id) begin
              res.out_thread_id = req.thread_id;
              res.out_level = 2'(lvl);
              res.status = ST_OK;
              drop_ready_entry(lvl, pos);
              found = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic in_item_t make_req(input logic [1:0] kind, input logic [15:0] id,
                                        input logic [2:0] prio);
    in_item_t req;
    req.kind = kind;
    req.thread_id = id;
    req.priority_req = prio;
    return req;
  endfunction

  task automatic report_failure(input string what, input out_item_t want,
                                input out_item_t got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("error: %s at %0t: expected status %0d id %h level %0d,", what, $realtime,
               want.status, want.out_thread_id, want.out_level,
               " got status %0d id %h level %0d",
               got.status, got.out_thread_id, got.out_level);
    end
  endtask

  // Every strobed result is matched against the oldest pending expectation.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        report_failure("result with nothing pending", '0, out_item);
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_item.status !== oldest_result.status ||
            out_item.out_thread_id !== oldest_result.out_thread_id ||
            out_item.out_level !== oldest_result.out_level) begin
          report_failure("result mismatch", oldest_result, out_item);
        end
      end
    end
  end

  // Offer one request and hold it until the transfer happens; optionally idle after.
  task automatic send_request(input in_item_t req, input bit idle_on);
    start <= 1'b1;
    in_item <= req;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(schedule_outcome(req));
    if (idle_on && $urandom_range(0, 99) < 16) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Stop offering requests until every expected result has come back.
  task automatic wait_all_results();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Empty queues, bad priorities and the unused kind.
  task automatic test_empty_and_invalid();
    send_request(make_req(KIND_DEQ, 16'hFFFF, 3'd7), 1'b0);
    send_request(make_req(KIND_REMOVE, 16'h1234, 3'd0), 1'b0);
    send_request(make_req(KIND_UNUSED, 16'hFFFF, 3'd7), 1'b0);
    send_request(make_req(KIND_ENQ, 16'hAAAA, 3'd4), 1'b0);
    send_request(make_req(KIND_ENQ, 16'h5555, 3'd7), 1'b0);
  endtask

  // Priority order, FIFO order, duplicate ids and order-keeping removal.
  task automatic test_order_and_removal();
    send_request(make_req(KIND_ENQ, 16'hFFFF, 3'd3), 1'b0);
    send_request(make_req(KIND_ENQ, 16'h0000, 3'd0), 1'b0);
    send_request(make_req(KIND_ENQ, 16'h00A5, 3'd1), 1'b0);
    send_request(make_req(KIND_ENQ, 16'h5A00, 3'd1), 1'b0);
    send_request(make_req(KIND_ENQ, 16'h00A5, 3'd2), 1'b0);
    send_request(make_req(KIND_ENQ, 16'h00A5, 3'd1), 1'b0);
    send_request(make_req(KIND_ENQ, 16'h8001, 3'd2), 1'b0);
    send_request(make_req(KIND_REMOVE, 16'h00A5, 3'd6), 1'b0);
    send_request(make_req(KIND_REMOVE, 16'h8001, 3'd0), 1'b0);
    send_request(make_req(KIND_REMOVE, 16'h0000, 3'd0), 1'b0);
    send_request(make_req(KIND_REMOVE, 16'h7777, 3'd0), 1'b0);
    repeat (5) send_request(make_req(KIND_DEQ, 16'($urandom), 3'($urandom)), 1'b0);
  endtask

  // Fill level 3, the lowest-priority level, to the brim; one more enqueue must be refused.
  task automatic test_full_level();
    for (int i = 0; i < QDEPTH; i++) begin
      send_request(make_req(KIND_ENQ, 16'(i * 4099 + 1), 3'd3), 1'b0);
    end
    send_request(make_req(KIND_ENQ, 16'hFFFF, 3'd3), 1'b0);
  endtask

  // Random traffic; the percentages steer the queues toward full or empty.
  task automatic test_random_traffic(input int count, input int enq_pct, input int deq_pct,
                                     input bit idle_on);
    in_item_t req;
    int       roll;
    int       total;
    int       pick;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      req.thread_id = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 15));
      req.priority_req = 3'($urandom);
      if (roll < enq_pct) begin
        req.kind = KIND_ENQ;
        if ($urandom_range(0, 9) != 0) req.priority_req = 3'($urandom_range(0, 3));
      end else if (roll < enq_pct + deq_pct) begin
        req.kind = KIND_DEQ;
      end else if (roll < 97) begin
        req.kind = KIND_REMOVE;
        // Mostly remove an id that is queued somewhere, so removal hits.
        total = 0;
        foreach (ready_fill[l]) total += ready_fill[l];
        if (total > 0 && $urandom_range(0, 9) < 7) begin
          pick = $urandom_range(0, total - 1);
          for (int l = 0; l < NLEVELS; l++) begin
            if (pick >= 0 && pick < ready_fill[l]) req.thread_id = ready_ids[l][pick];
            pick -= ready_fill[l];
          end
        end
      end else begin
        req.kind = KIND_UNUSED;
      end
      send_request(req, idle_on);
      if ($urandom_range(0, 49) == 0) wait_all_results();
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_item <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_and_invalid();
    test_order_and_removal();
    test_full_level();
    wait_all_results();
    test_random_traffic(200, 45, 25, 1'b1);
    wait_all_results();
    test_random_traffic(200, 75, 10, 1'b0);
    wait_all_results();
    test_random_traffic(200, 20, 45, 1'b1);
    wait_all_results();

    // Leave room for any stray result after the last expected one.
    repeat (300) @(posedge clk);
    fail_count += pending_results.size();
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  // Run limit, far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

endmodule

/* filelist.f */
sv/mpq_pkg.sv
sv/multilevel_priority_ready_queue.sv
sv/mpq_checker.sv
verif/tb.sv
